[design/hxtok_pkg.sv]
// ----------------------------------------------------------------------------
// hxtok_pkg: shared types and constants of the hex hash token reader
// Character codes, status codes, character classification and the control
// bundle that hands a finished read to the result stage.
// ----------------------------------------------------------------------------
package hxtok_pkg;

   localparam int WORD_W    = 64;
   localparam int NIB_W     = 4;
   localparam int CHAR_W    = 8;
   localparam int CNT_W     = 7;
   localparam int LEN_W     = 6;
   localparam int IDX_MAX_W = 3;

   localparam logic [LEN_W-1:0] HASH_BYTES_RST = 6'd20;

   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
   localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;
   localparam logic [CHAR_W-1:0] ALPHA_OFS = 8'h37;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_NONE = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   // Load request for the result stage
   typedef struct packed {
      logic                 load_words;
      logic                 load_single;
      status_type           single_status;
      logic [IDX_MAX_W-1:0] top_idx;
   } emit_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_break(input logic [CHAR_W-1:0] c);
      return (c == CH_CR) || (c == CH_LF);
   endfunction

   // Bit 4 flags a character that is no hex digit; bits 3:0 carry the value
   function automatic logic [NIB_W:0] hex_decode(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] u;
      logic [CHAR_W-1:0] d;
      logic [NIB_W:0]    r;
      u = c & ~CASE_BIT;
      r = {1'b1, {NIB_W{1'b0}}};
      if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
         d = c - CH_ZERO;
         r = {1'b0, d[NIB_W-1:0]};
      end else if ((u >= CH_UPPER_A) && (u <= CH_UPPER_F)) begin
         d = u - ALPHA_OFS;
         r = {1'b0, d[NIB_W-1:0]};
      end
      return r;
   endfunction

endpackage

[design/hxtok_cell.sv]
// ----------------------------------------------------------------------------
// hxtok_cell: one 64-bit word of the digit accumulator
// Shifts a nibble in at the low end and hands its top nibble to the next
// cell of the chain.
// ----------------------------------------------------------------------------
module hxtok_cell
   import hxtok_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic              clear_en,
   input  logic [NIB_W-1:0]  nib_in,
   output logic [NIB_W-1:0]  nib_out,
   output logic [WORD_W-1:0] word_out
);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   // Clear wins over shift
   always_comb begin
      word_in = word_ff;
      if (clear_en) begin
         word_in = '0;
      end else if (shift_en) begin
         word_in = {word_ff[WORD_W-NIB_W-1:0], nib_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign nib_out  = word_ff[WORD_W-1:WORD_W-NIB_W];
   assign word_out = word_ff;

endmodule

[design/hxtok_out.sv]
// ----------------------------------------------------------------------------
// hxtok_out: result stage
// Holds a snapshot of the hash words and plays them out most significant
// first, followed by an optional single status transaction.
// ----------------------------------------------------------------------------
module hxtok_out
   import hxtok_pkg::*;
#(
   parameter int ACC_WORDS = 4,
   parameter int IDX_W     = 2
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  emit_type                         emit,
   input  logic [ACC_WORDS-1:0][WORD_W-1:0] snap_words,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [WORD_W-1:0]                rsp_hash_word,
   output logic                             rsp_last
);

   logic [WORD_W-1:0] word_ff [ACC_WORDS];
   logic              word_pend_ff;
   logic              single_pend_ff;
   status_type        single_status_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              take;

   assign take = rsp_valid & ~rsp_stall;

   // Capture the hash words
   always_ff @(posedge clock) begin
      if (emit.load_words) begin
         for (int i = 0; i < ACC_WORDS; i++) begin
            word_ff[i] <= snap_words[i];
         end
      end
   end

   // Track pending transactions; advance the word pointer on each handoff
   always_ff @(posedge clock) begin
      if (reset) begin
         word_pend_ff   <= 1'b0;
         single_pend_ff <= 1'b0;
      end else if (emit.load_words || emit.load_single) begin
         word_pend_ff   <= emit.load_words;
         single_pend_ff <= emit.load_single;
      end else if (take) begin
         if (word_pend_ff) begin
            if (rd_idx_ff == '0) begin
               word_pend_ff <= 1'b0;
            end
         end else begin
            single_pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit.load_words || emit.load_single) begin
         single_status_ff <= emit.single_status;
         rd_idx_ff        <= emit.top_idx[IDX_W-1:0];
      end else if (take && word_pend_ff && (rd_idx_ff != '0)) begin
         rd_idx_ff <= rd_idx_ff - 1'b1;
      end
   end

   assign rsp_valid     = word_pend_ff | single_pend_ff;
   assign rsp_status    = word_pend_ff ? ST_OK : single_status_ff;
   assign rsp_hash_word = word_pend_ff ? word_ff[rd_idx_ff] : '0;
   assign rsp_last      = word_pend_ff ? (rd_idx_ff == '0) : 1'b1;

endmodule

[design/hex_hash_token_reader_unit.sv]
// Results: the first result transaction of a token-ending character is registered
// in the result stage and offered from there, then one word per cycle while rsp_stall is low.
// Throughput: one character per cycle; a character that ends a read is held
// off while the result stage still drains the previous read.
// Reset: synchronous, active high; clears the accumulator chain, the token
// state and pending results, and sets hash_bytes to 20.
// ----------------------------------------------------------------------------
// hex_hash_token_reader_unit: hex hash token reader
// Skips leading whitespace, gathers hex digits into a chain of word cells
// and emits the right-aligned hash as 64-bit words on end of token.
// ----------------------------------------------------------------------------
module hex_hash_token_reader_unit
   import hxtok_pkg::*;
#(
   parameter int MAX_HASH_BYTES = 32
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [LEN_W-1:0]  csr_hash_bytes,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic              req_stream_end,
   input  logic              req_skip_breaks,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [WORD_W-1:0] rsp_hash_word,
   output logic              rsp_last
);

   localparam int ACC_WORDS = (MAX_HASH_BYTES + 7) / 8;
   localparam int IDX_W     = (ACC_WORDS > 1) ? $clog2(ACC_WORDS) : 1;
   localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_HASH_BYTES);

   logic [LEN_W-1:0]                 hash_bytes_ff;
   logic                             in_token_ff;
   logic                             in_token_in;
   logic [CNT_W-1:0]                 digit_cnt_ff;
   logic [CNT_W-1:0]                 digit_cnt_in;
   logic [CNT_W-1:0]                 eff_len;
   logic [CNT_W:0]                   len_round;
   logic [CNT_W-3:0]                 num_words;
   logic [IDX_MAX_W-1:0]             top_idx;
   logic [WORD_W-1:0]                top_mask;
   logic [ACC_WORDS-1:0][WORD_W-1:0] acc_word;
   logic [ACC_WORDS-1:0][WORD_W-1:0] snap_word;
   logic [ACC_WORDS-1:0][NIB_W-1:0]  carry_nib;
   logic [NIB_W:0]                   hex_res;
   logic                             ch_space;
   logic                             ch_break;
   logic                             ch_bad;
   logic                             over_len;
   logic                             plan_shift;
   logic                             plan_clear;
   logic                             plan_words;
   logic                             plan_single;
   status_type                       plan_status;
   logic                             take;
   emit_type                         emit;

   // Hold the length register
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_bytes_ff <= HASH_BYTES_RST;
      end else if (csr_write_en) begin
         hash_bytes_ff <= csr_hash_bytes;
      end
   end

   // Clamp the length and derive word count and top-word mask
   always_comb begin
      if (hash_bytes_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if ({1'b0, hash_bytes_ff} > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = {1'b0, hash_bytes_ff};
      end
      len_round = {1'b0, eff_len} + (CNT_W + 1)'(7);
      num_words = len_round[CNT_W:3];
      top_idx   = IDX_MAX_W'(num_words - 1'b1);
      if (eff_len[2:0] == 3'd0) begin
         top_mask = '1;
      end else begin
         top_mask = (WORD_W'(1) << {eff_len[2:0], 3'b000}) - WORD_W'(1);
      end
   end

   // Classify the character
   assign hex_res  = hex_decode(req_char_code);
   assign ch_space = is_space(req_char_code);
   assign ch_break = is_break(req_char_code);
   assign ch_bad   = hex_res[NIB_W];
   assign over_len = {1'b0, digit_cnt_ff} >= {eff_len, 1'b0};

   // Decide what this character does
   always_comb begin
      plan_shift  = 1'b0;
      plan_clear  = 1'b0;
      plan_words  = 1'b0;
      plan_single = 1'b0;
      plan_status = ST_NONE;
      in_token_in  = in_token_ff;
      digit_cnt_in = digit_cnt_ff;
      if (in_token_ff) begin
         if (req_stream_end || ch_space) begin
            plan_clear   = 1'b1;
            in_token_in  = 1'b0;
            digit_cnt_in = '0;
            if (digit_cnt_ff[0]) begin
               plan_single = 1'b1;
               plan_status = ST_BAD;
            end else begin
               plan_words  = 1'b1;
               plan_single = ~req_stream_end & ~req_skip_breaks & ch_break;
            end
         end else if (ch_bad || over_len) begin
            plan_clear   = 1'b1;
            in_token_in  = 1'b0;
            digit_cnt_in = '0;
            plan_single  = 1'b1;
            plan_status  = ST_BAD;
         end else begin
            plan_shift   = 1'b1;
            digit_cnt_in = digit_cnt_ff + 1'b1;
         end
      end else begin
         if (req_stream_end || (~req_skip_breaks && ch_break)) begin
            plan_single = 1'b1;
         end else if (!ch_space) begin
            if (ch_bad) begin
               plan_single = 1'b1;
               plan_status = ST_BAD;
            end else begin
               plan_shift   = 1'b1;
               in_token_in  = 1'b1;
               digit_cnt_in = CNT_W'(1);
            end
         end
      end
   end

   // Hold off a read's end while earlier results still drain
   assign req_stall = rsp_valid & (plan_words | plan_single);
   assign take      = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff  <= 1'b0;
         digit_cnt_ff <= '0;
      end else if (take) begin
         in_token_ff  <= in_token_in;
         digit_cnt_ff <= digit_cnt_in;
      end
   end

   // Accumulator chain: cell 0 takes the new digit
   for (genvar g = 0; g < ACC_WORDS; g++) begin : g_cell
      logic [NIB_W-1:0] nib_src;
      if (g == 0) begin : g_head
         assign nib_src = hex_res[NIB_W-1:0];
      end else begin : g_body
         assign nib_src = carry_nib[g-1];
      end
      hxtok_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (take & plan_shift),
         .clear_en (take & plan_clear),
         .nib_in   (nib_src),
         .nib_out  (carry_nib[g]),
         .word_out (acc_word[g])
      );
   end

   // Drop gathered bits above the current length
   always_comb begin
      for (int i = 0; i < ACC_WORDS; i++) begin
         snap_word[i] = acc_word[i] & ((IDX_MAX_W'(i) == top_idx) ? top_mask : '1);
      end
   end

   always_comb begin
      emit.load_words    = take & plan_words;
      emit.load_single   = take & plan_single;
      emit.single_status = plan_status;
      emit.top_idx       = top_idx;
   end

   hxtok_out #(
      .ACC_WORDS (ACC_WORDS),
      .IDX_W     (IDX_W)
   ) u_out (
      .clock         (clock),
      .reset         (reset),
      .emit          (emit),
      .snap_words    (snap_word),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_hash_word (rsp_hash_word),
      .rsp_last      (rsp_last)
   );

`ifndef SYNTHESIS
   // Skipping mode always starts from an empty accumulator
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !in_token_ff |-> (digit_cnt_ff == '0) && (acc_word == '0))
      else $error("accumulator not empty while skipping");

   // A read's end is never taken over pending results
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (take && (plan_words || plan_single)) |-> !rsp_valid)
      else $error("result stage overrun");

   // A finished read shows up at the result port next cycle
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (take && (plan_words || plan_single)) |=> rsp_valid)
      else $error("finished read not presented");

   // Inside a token the digit count is never zero
   a_token_cnt: assert property (@(posedge clock) disable iff (reset)
      in_token_ff |-> (digit_cnt_ff != '0))
      else $error("token without digits");
`endif

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: hex hash token reader, self-checking
// Feeds text characters and end-of-stream marks through the request channel,
// tracks the expected hash words, "no hash" and invalid-format results in a
// local prediction of the reader, and compares every result transaction field
// by field. Sweeps the hash length register over its extremes and idles both
// channels in several patterns.
// ----------------------------------------------------------------------------
module testbench
   import hxtok_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 20;
   localparam int ITEMS_PER_PHASE = 25;
   localparam int HASH_MAX        = 32;
   localparam int ACC_W           = HASH_MAX * 8;

   localparam logic [CHAR_W-1:0] CH_VT      = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF      = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              at_end;
      logic              skip_breaks;
   } text_item_type;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] word;
      logic              last;
   } hash_result_type;

   logic              clock;
   logic              reset           = 1'b1;
   logic              csr_write_en    = 1'b0;
   logic [LEN_W-1:0]  csr_hash_bytes  = HASH_BYTES_RST;
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic [CHAR_W-1:0] req_char_code   = '0;
   logic              req_stream_end  = 1'b0;
   logic              req_skip_breaks = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   logic [1:0]        rsp_status;
   logic [WORD_W-1:0] rsp_hash_word;
   logic              rsp_last;

   // Stimulus and expectation stores
   text_item_type   pending_chars[$];
   hash_result_type expected_words[$];
   int              queued_items   = 0;
   int              mismatch_count = 0;
   int              send_idle_pct  = 0;
   int              stall_pct      = 0;
   int              hold_id        = 0;
   int              hold_served    = 0;
   int              hold_left      = 0;
   int              quiet_cycles   = 0;
   logic            req_fired      = 1'b0;

   // Local copy of the reader state
   logic [ACC_W-1:0] acc_bits   = '0;
   logic [CNT_W-1:0] acc_digits = '0;
   logic             in_digits  = 1'b0;
   logic [LEN_W-1:0] len_shadow = HASH_BYTES_RST;

   hex_hash_token_reader_unit u_top (.*);

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // ---------------------------------------------------------------- prediction

   function automatic int eff_bytes(input logic [LEN_W-1:0] v);
      if (v == '0) return 1;
      if (v > HASH_MAX) return HASH_MAX;
      return int'(v);
   endfunction

   function automatic logic white(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic line_break(input logic [CHAR_W-1:0] c);
      return (c == CH_CR) || (c == CH_LF);
   endfunction

   // Top bit set means not a hex digit
   function automatic logic [NIB_W:0] digit_value(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] u;
      logic [CHAR_W-1:0] d;
      u = c & ~CASE_BIT;
      if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
         d = c - CH_ZERO;
         return {1'b0, d[NIB_W-1:0]};
      end
      if ((u >= CH_UPPER_A) && (u <= CH_UPPER_F)) begin
         d = u - CH_UPPER_A + 8'd10;
         return {1'b0, d[NIB_W-1:0]};
      end
      return {1'b1, {NIB_W{1'b0}}};
   endfunction

   task automatic clear_acc();
      acc_bits   = '0;
      acc_digits = '0;
      in_digits  = 1'b0;
   endtask

   task automatic shift_digit(input logic [NIB_W-1:0] nib);
      acc_bits   = {acc_bits[ACC_W-NIB_W-1:0], nib};
      acc_digits = acc_digits + 1'b1;
   endtask

   task automatic push_result(input status_type s, input logic [WORD_W-1:0] w,
                              input logic l);
      hash_result_type r;
      r.status = s;
      r.word   = w;
      r.last   = l;
      expected_words.push_back(r);
   endtask

   // Advance the reader state by one character and queue what it produces
   task automatic predict_char(input text_item_type it);
      logic [NIB_W:0]    dv;
      logic [WORD_W-1:0] w;
      int                hb;
      int                nw;
      int                k;
      hb = eff_bytes(len_shadow);
      dv = digit_value(it.code);
      if (in_digits) begin
         if (it.at_end || white(it.code)) begin
            if (acc_digits[0]) begin
               clear_acc();
               push_result(ST_BAD, '0, 1'b1);
            end else begin
               // emit right-aligned words, top one masked to the hash length
               nw = (hb + 7) / 8;
               for (k = 0; k < nw; k++) begin
                  w = acc_bits[(nw - 1 - k) * WORD_W +: WORD_W];
                  if (k == 0 && (hb % 8) != 0)
                     w = w & ((64'd1 << (8 * (hb % 8))) - 64'd1);
                  push_result(ST_OK, w, k == nw - 1);
               end
               clear_acc();
               // a line break that is not skipped also gives a no-hash result
               if (!it.at_end && !it.skip_breaks && line_break(it.code))
                  push_result(ST_NONE, '0, 1'b1);
            end
         end else if (dv[NIB_W] || acc_digits >= 2 * hb) begin
            clear_acc();
            push_result(ST_BAD, '0, 1'b1);
         end else begin
            shift_digit(dv[NIB_W-1:0]);
         end
      end else if (it.at_end || (!it.skip_breaks && line_break(it.code))) begin
         push_result(ST_NONE, '0, 1'b1);
      end else if (!white(it.code)) begin
         if (dv[NIB_W]) begin
            push_result(ST_BAD, '0, 1'b1);
         end else begin
            shift_digit(dv[NIB_W-1:0]);
            in_digits = 1'b1;
         end
      end
   endtask

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : monitor
      hash_result_type want;
      if (reset) begin
         clear_acc();
         len_shadow = HASH_BYTES_RST;
         expected_words.delete();
         quiet_cycles = 0;
         req_fired <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_char({req_char_code, req_stream_end, req_skip_breaks});
         // a register write at this edge applies from the next transaction on
         if (csr_write_en) len_shadow = csr_hash_bytes;
         // compare each result transaction with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result transaction: status %0d word %h last %0b",
                      rsp_status, rsp_hash_word, rsp_last);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_hash_word !== want.word) begin
                  $error("hash_word: expected %h, actual %h", want.word, rsp_hash_word);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         req_fired <= req_valid && !req_stall;
         // watchdog on cycles with no transaction on either channel
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL hex_hash_token_reader_unit");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- driver

   // Hold the current character until it is taken, then offer the next one
   always @(negedge clock) begin : sender
      text_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_chars.pop_front();
            req_valid       <= 1'b1;
            req_char_code   <= nxt.code;
            req_stream_end  <= nxt.at_end;
            req_skip_breaks <= nxt.skip_breaks;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall results at random, or for a long stretch when a hold is requested
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_id != hold_served) begin
         hold_served = hold_id;
         hold_left   = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_char(input logic [CHAR_W-1:0] c, input logic e, input logic sb);
      text_item_type it;
      it.code        = c;
      it.at_end      = e;
      it.skip_breaks = sb;
      pending_chars.push_back(it);
      queued_items++;
   endtask

   function automatic logic rand_bit();
      return $urandom_range(1) != 0;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] v);
      if (v < 10) return CH_ZERO + {4'b0, v};
      return (rand_bit() ? CH_UPPER_A : CH_LOWER_A) + {4'b0, v} - 8'd10;
   endfunction

   function automatic logic [CHAR_W-1:0] rand_space();
      case ($urandom_range(5))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_LF;
         3: return CH_VT;
         4: return CH_FF;
         default: return CH_CR;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] non_hex_char();
      logic [CHAR_W-1:0] c;
      logic [NIB_W:0]    dv;
      do begin
         c  = 8'($urandom());
         dv = digit_value(c);
      end while (!dv[NIB_W] || white(c));
      return c;
   endfunction

   // Queue one read: leading whitespace, then digits and a terminator, or raw noise
   task automatic add_read(input int hb);
      int pre;
      int nd;
      int kind;
      int k;
      pre = $urandom_range(2);
      for (k = 0; k < pre; k++) push_char(rand_space(), 1'b0, rand_bit());
      kind = $urandom_range(99);
      if (kind < 70)
         nd = ($urandom_range(3) == 0) ? 2 * hb : 2 * $urandom_range(hb < 4 ? hb : 4, 1);
      else if (kind < 78)
         nd = 2 * $urandom_range(hb - 1) + 1;
      else if (kind < 86)
         nd = 2 * hb + 1;
      else if (kind < 94)
         nd = $urandom_range(3);
      else
         nd = -1;
      // raw noise: any byte, any flags
      if (nd < 0) begin
         pre = $urandom_range(3, 1);
         for (k = 0; k < pre; k++) push_char(8'($urandom()), rand_bit(), rand_bit());
         return;
      end
      for (k = 0; k < nd; k++) push_char(digit_char(4'($urandom())), 1'b0, rand_bit());
      if (kind >= 86 && kind < 94) push_char(non_hex_char(), 1'b0, rand_bit());
      if ($urandom_range(3) == 0)
         push_char(8'($urandom()), 1'b1, rand_bit());
      else
         push_char(rand_space(), 1'b0, rand_bit());
   endtask

   // Wait until every character is taken and every result has come
   task automatic wait_drained();
      while (pending_chars.size() != 0 || req_valid || expected_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_len(input logic [LEN_W-1:0] v);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_hash_bytes <= v;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin : stimulus
      logic [LEN_W-1:0] phase_len[6];
      int               p;
      int               start;
      phase_len = '{6'd1, 6'd32, 6'd8, 6'd0, 6'd63, 6'd17};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed reads at the reset length of 20 bytes
      push_char(8'h00, 1'b1, 1'b0);                  // end of stream while skipping
      push_char(CH_LF, 1'b0, 1'b0);                  // line break not skipped
      push_char(CH_CR, 1'b0, 1'b1);                  // line break skipped
      push_char(8'h30, 1'b0, 1'b0);
      push_char(8'h39, 1'b0, 1'b0);
      push_char(8'h61, 1'b0, 1'b0);
      push_char(8'h46, 1'b0, 1'b0);
      push_char(CH_LF, 1'b0, 1'b0);                  // hash, then no hash
      push_char(8'h41, 1'b0, 1'b1);
      push_char(8'h62, 1'b0, 1'b1);
      push_char(8'hFF, 1'b1, 1'b1);                  // end of stream inside a token
      push_char(8'h31, 1'b0, 1'b0);
      push_char(8'h32, 1'b0, 1'b0);
      push_char(8'h33, 1'b0, 1'b0);
      push_char(CH_SPACE, 1'b0, 1'b0);               // odd digit count
      push_char(8'h67, 1'b0, 1'b0);                  // non-hex while skipping
      push_char(8'h31, 1'b0, 1'b0);
      push_char(8'h78, 1'b0, 1'b0);                  // non-hex inside a token
      push_char(8'hFF, 1'b0, 1'b1);
      wait_drained();

      // too many digits, then a length change inside a token
      write_len(6'd1);
      push_char(8'h66, 1'b0, 1'b0);
      push_char(8'h65, 1'b0, 1'b0);
      push_char(8'h64, 1'b0, 1'b0);
      push_char(8'h31, 1'b0, 1'b0);
      push_char(8'h32, 1'b0, 1'b0);
      wait_drained();
      write_len(6'd2);
      push_char(8'h33, 1'b0, 1'b0);
      push_char(8'h34, 1'b0, 1'b0);
      push_char(8'h00, 1'b1, 1'b0);
      wait_drained();

      // random reads over a sweep of lengths and idle patterns
      for (p = 0; p < 6; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 71; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 71; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
         endcase
         write_len(phase_len[p]);
         // back up the result side while the sender floods the reader
         if (p == 4) hold_id++;
         start = queued_items;
         while (queued_items - start < ITEMS_PER_PHASE) add_read(eff_bytes(phase_len[p]));
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_words.size() != 0) begin
         $error("%0d expected result transactions never arrived", expected_words.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("PASS hex_hash_token_reader_unit");
      else
         $display("FAIL hex_hash_token_reader_unit");
      $finish;
   end

endmodule

[files.f]
design/hxtok_pkg.sv
design/hxtok_cell.sv
design/hxtok_out.sv
design/hex_hash_token_reader_unit.sv
tb/testbench.sv
